// File: hdl/bthm_pkg.sv
// ---------------------------------------------------------------------------
// bthm_pkg
// Shared types, codes and hash round function for the level-tagged hash map.
// ---------------------------------------------------------------------------
package bthm_pkg;

   localparam int REQ_W = 3;
   localparam int KEY_W = 31;
   localparam int CFG_W = 11;
   localparam int STATUS_W = 3;

   localparam logic [31:0] SLOT_EMPTY   = 32'hFFFF_FFFF;
   localparam logic [31:0] SLOT_DELETED = 32'hFFFF_FFFE;
   localparam logic [31:0] VALUE_UNSET  = 32'hFFFF_FFFF;

   localparam logic [31:0] HASH_C0 = 32'h7ed5_5d16;
   localparam logic [31:0] HASH_C1 = 32'hc761_c23c;
   localparam logic [31:0] HASH_C2 = 32'h1656_67b1;
   localparam logic [31:0] HASH_C3 = 32'hd3a2_646c;
   localparam logic [31:0] HASH_C4 = 32'hfd70_46c5;
   localparam logic [31:0] HASH_C5 = 32'hb55a_4f09;
   localparam logic [2:0]  HASH_LAST_ROUND = 3'd5;

   typedef enum logic [REQ_W-1:0] {
      REQ_FIND  = 3'd0,
      REQ_GET   = 3'd1,
      REQ_SET   = 3'd2,
      REQ_PUSH  = 3'd3,
      REQ_POP   = 3'd4,
      REQ_RESET = 3'd5
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_POP_ZERO  = 3'd2,
      ST_SET_MISS  = 3'd3,
      ST_LEVEL_OVF = 3'd4
   } status_code_type;

   typedef enum logic [0:0] {
      CSR_FILL_LIMIT    = 1'b0,
      CSR_CLEANUP_LIMIT = 1'b1
   } csr_index_type;

   // One round of the 32-bit integer mix.
   function automatic logic [31:0] hash_round(input logic [31:0] x, input logic [2:0] r);
      logic [31:0] y;
      y = x;
      case (r)
         3'd0:    y = (x + HASH_C0) + (x << 12);
         3'd1:    y = (x ^ HASH_C1) ^ (x >> 19);
         3'd2:    y = (x + HASH_C2) + (x << 5);
         3'd3:    y = (x + HASH_C3) ^ (x << 9);
         3'd4:    y = (x + HASH_C4) + (x << 3);
         3'd5:    y = (x ^ HASH_C5) ^ (x >> 16);
         default: y = x;
      endcase
      return y;
   endfunction

endpackage

// File: hdl/bthm_ram.sv
// ---------------------------------------------------------------------------
// bthm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module bthm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/bthm_hash.sv
// ---------------------------------------------------------------------------
// bthm_hash
// Iterative integer hash: one mix round per cycle, six rounds.
// ---------------------------------------------------------------------------
module bthm_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] key,
   output logic        done,
   output logic [31:0] hash
);
   import bthm_pkg::*;

   logic [31:0] x_ff, x_in;
   logic [2:0]  round_ff, round_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   always_comb begin
      x_in     = x_ff;
      round_in = round_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         x_in     = key;
         round_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         x_in     = hash_round(x_ff, round_ff);
         round_in = round_ff + 3'd1;
         if (round_ff == HASH_LAST_ROUND) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   assign done = done_ff;
   assign hash = x_ff;

endmodule

// File: hdl/backtracking_int_hash_map.sv
// ---------------------------------------------------------------------------
// backtracking_int_hash_map
// Level-tagged open-addressing map with linear probing, pop by level and
// clean rehash into a second bank. One slot memory holds both banks.
// ---------------------------------------------------------------------------
//  channel   | handshake             | beat
//  request   | start, busy           | req_type, req_key, req_new_value
//  response  | rsp_valid (strobe)    | rsp_found ... rsp_level_now
//  csr       | csr_we                | csr_index, csr_wdata
//
//  Find/get/set: a hash, then a read and a check per probed slot; a get
//  that inserts adds a slot write, or at the fill limit with deleted slots
//  a cleanup and a second hash and probe. Push, pop at level zero, bad
//  codes: result the cycle after start. Pop: a read and a check per slot,
//  then an end state; a rehash adds a clear of the new bank, a read,
//  check and next state per old slot and a hash plus probe per moved
//  entry. Reset and reset request: the whole slot memory is cleared with
//  busy high. Results are strobed for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
module backtracking_int_hash_map #(
   parameter int TABLE_SIZE = 1024,
   parameter int LEVEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [bthm_pkg::REQ_W-1:0]     req_type,
   input  logic [bthm_pkg::KEY_W-1:0]     req_key,
   input  logic [bthm_pkg::KEY_W-1:0]     req_new_value,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic                           rsp_created,
   output logic signed [31:0]             rsp_entry_value,
   output logic [bthm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [10:0]                    rsp_removed_count,
   output logic [15:0]                    rsp_level_now,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [bthm_pkg::CFG_W-1:0]     csr_wdata
);
   import bthm_pkg::*;

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int AW = IW + 1;
   localparam int CW = $clog2(TABLE_SIZE + 1);
   localparam int MW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int EW = 64 + LEVEL_BITS;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
   localparam logic [AW-1:0] LAST_ADDR = {AW{1'b1}};

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_CLEAR   = 14'b00000000000010,
      S_HASH    = 14'b00000000000100,
      S_PRD     = 14'b00000000001000,
      S_PCHK    = 14'b00000000010000,
      S_GDEC    = 14'b00000000100000,
      S_GFILL   = 14'b00000001000000,
      S_POP_RD  = 14'b00000010000000,
      S_POP_CHK = 14'b00000100000000,
      S_POP_END = 14'b00001000000000,
      S_RH_CLR  = 14'b00010000000000,
      S_RH_RD   = 14'b00100000000000,
      S_RH_CHK  = 14'b01000000000000,
      S_RH_NEXT = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      M_LOOKUP = 3'd0,
      M_GETA   = 3'd1,
      M_GETB   = 3'd2,
      M_INSERT = 3'd3,
      M_MOVE   = 3'd4
   } probe_mode_type;

   state_type       state_ff, state_in;
   probe_mode_type  mode_ff, mode_in;
   logic [REQ_W-1:0] op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in, nv_ff, nv_in;
   logic [IW-1:0]   idx_ff, idx_in, n_ff, n_in, fs_idx_ff, fs_idx_in;
   logic            fs_del_ff, fs_del_in;
   logic [AW-1:0]   sweep_ff, sweep_in;
   logic            bank_ff, bank_in;
   logic [CW-1:0]   live_ff, live_in, del_ff, del_in, removed_ff, removed_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [CFG_W-1:0] fill_ff, fill_in, clean_ff, clean_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic            rh_get_ff, rh_get_in;
   logic [EW-1:0]   mv_ff, mv_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_found_ff, rsp_found_in, rsp_created_ff, rsp_created_in;
   logic [31:0]     rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [10:0]     rsp_removed_ff, rsp_removed_in;
   logic [15:0]     rsp_level_ff, rsp_level_in;

   logic            ram_we;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [EW-1:0]   ram_wdata, ram_rdata;
   logic            hash_start, hash_done;
   logic [31:0]     mix_key, hash_value;

   logic [31:0]     rd_key, rd_val;
   logic [LEVEL_BITS-1:0] rd_lvl;
   logic            rd_live, rd_hit, rd_empty, last_n;
   logic [IW-1:0]   idx_next, home_idx;
   logic            probe_bank;
   logic [CW-1:0]   pop_live, pop_del;
   logic [31:0]     rem32, lvl32;

   assign rd_key   = ram_rdata[31:0];
   assign rd_val   = ram_rdata[63:32];
   assign rd_lvl   = ram_rdata[EW-1:64];
   assign rd_live  = !rd_key[31];
   assign rd_hit   = (rd_key == {1'b0, key_ff});
   assign rd_empty = (rd_key == SLOT_EMPTY);
   assign last_n   = (n_ff == LAST_IDX);
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1);
   assign home_idx = IW'(hash_value % 32'(TABLE_SIZE));
   assign probe_bank = (mode_ff == M_MOVE) ? !bank_ff : bank_ff;
   assign pop_live = live_ff - ((removed_ff <= live_ff) ? removed_ff : live_ff);
   assign pop_del  = del_ff + removed_ff;
   assign rem32    = 32'(removed_ff);
   assign lvl32    = 32'(level_in);

   bthm_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bthm_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (mix_key),
      .done  (hash_done),
      .hash  (hash_value)
   );

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      nv_in      = nv_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      fs_idx_in  = fs_idx_ff;
      fs_del_in  = fs_del_ff;
      sweep_in   = sweep_ff;
      bank_in    = bank_ff;
      live_in    = live_ff;
      del_in     = del_ff;
      removed_in = removed_ff;
      level_in   = level_ff;
      fill_in    = fill_ff;
      clean_in   = clean_ff;
      clr_rsp_in = clr_rsp_ff;
      rh_get_in  = rh_get_ff;
      mv_in      = mv_ff;

      rsp_valid_in   = 1'b0;
      rsp_found_in   = 1'b0;
      rsp_created_in = 1'b0;
      rsp_value_in   = VALUE_UNSET;
      rsp_status_in  = ST_OK;
      rsp_removed_in = '0;

      ram_we     = 1'b0;
      ram_waddr  = {probe_bank, idx_ff};
      ram_wdata  = ram_rdata;
      ram_raddr  = {probe_bank, idx_ff};
      hash_start = 1'b0;
      mix_key    = {1'b0, key_ff};

      if (csr_we) begin
         unique case (csr_index)
            CSR_FILL_LIMIT:    fill_in  = csr_wdata;
            CSR_CLEANUP_LIMIT: clean_in = csr_wdata;
            default:           fill_in  = fill_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_type;
               key_in = req_key;
               nv_in  = req_new_value;
               unique case (req_type) inside
                  REQ_FIND, REQ_SET, REQ_GET: begin
                     hash_start = 1'b1;
                     mix_key    = {1'b0, req_key};
                     mode_in    = (req_type == REQ_GET) ? M_GETA : M_LOOKUP;
                     state_in   = S_HASH;
                  end
                  REQ_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (level_ff == LEVEL_MAX) begin
                        rsp_status_in = ST_LEVEL_OVF;
                     end else begin
                        level_in = level_ff + LEVEL_BITS'(1);
                     end
                  end
                  REQ_POP: begin
                     if (level_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_POP_ZERO;
                     end else begin
                        sweep_in   = '0;
                        removed_in = '0;
                        state_in   = S_POP_RD;
                     end
                  end
                  REQ_RESET: begin
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end

         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = {{LEVEL_BITS{1'b0}}, 32'd0, SLOT_EMPTY};
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               bank_in  = 1'b0;
               live_in  = '0;
               del_in   = '0;
               level_in = '0;
               rsp_valid_in = clr_rsp_ff;
               clr_rsp_in   = 1'b0;
               state_in = S_IDLE;
            end
         end

         S_HASH: begin
            if (hash_done) begin
               idx_in   = home_idx;
               n_in     = '0;
               state_in = S_PRD;
            end
         end

         S_PRD: state_in = S_PCHK;

         S_PCHK: begin
            ram_waddr = {probe_bank, idx_ff};
            case (mode_ff)
               M_LOOKUP: begin
                  if (rd_live && rd_hit) begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = 1'b1;
                     rsp_value_in = rd_val;
                     if (op_ff == REQ_SET) begin
                        ram_we       = 1'b1;
                        ram_wdata    = {rd_lvl, {1'b0, nv_ff}, rd_key};
                        rsp_value_in = {1'b0, nv_ff};
                     end
                     state_in = S_IDLE;
                  end else if (rd_empty || last_n) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = (op_ff == REQ_SET) ? ST_SET_MISS : ST_OK;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in   = idx_next;
                     n_in     = n_ff + IW'(1);
                     state_in = S_PRD;
                  end
               end
               M_GETA, M_GETB: begin
                  if (rd_live && rd_hit) begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = 1'b1;
                     rsp_value_in = rd_val;
                     state_in     = S_IDLE;
                  end else if (mode_ff == M_GETA && rd_live) begin
                     if (last_n) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                        state_in      = S_IDLE;
                     end else begin
                        idx_in   = idx_next;
                        n_in     = n_ff + IW'(1);
                        state_in = S_PRD;
                     end
                  end else begin
                     // first free slot found: remember it, then scan to an empty slot
                     if (mode_ff == M_GETA) begin
                        fs_idx_in = idx_ff;
                        fs_del_in = (rd_key == SLOT_DELETED);
                     end
                     if (rd_empty || last_n) begin
                        state_in = S_GDEC;
                     end else begin
                        mode_in  = M_GETB;
                        idx_in   = idx_next;
                        n_in     = n_ff + IW'(1);
                        state_in = S_PRD;
                     end
                  end
               end
               M_INSERT: begin
                  if (!rd_live) begin
                     ram_we         = 1'b1;
                     ram_wdata      = {level_ff, VALUE_UNSET, {1'b0, key_ff}};
                     live_in        = live_ff + CW'(1);
                     rsp_valid_in   = 1'b1;
                     rsp_created_in = 1'b1;
                     state_in       = S_IDLE;
                  end else if (last_n) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in   = idx_next;
                     n_in     = n_ff + IW'(1);
                     state_in = S_PRD;
                  end
               end
               M_MOVE: begin
                  if (!rd_live) begin
                     ram_we    = 1'b1;
                     ram_wdata = mv_ff;
                     state_in  = S_RH_NEXT;
                  end else if (last_n) begin
                     state_in = S_RH_NEXT;
                  end else begin
                     idx_in   = idx_next;
                     n_in     = n_ff + IW'(1);
                     state_in = S_PRD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_GDEC: begin
            if ((MW'(live_ff) + MW'(del_ff)) >= MW'(fill_ff)) begin
               if (del_ff != '0) begin
                  sweep_in  = '0;
                  rh_get_in = 1'b1;
                  state_in  = S_RH_CLR;
               end else begin
                  state_in = S_GFILL;
               end
            end else begin
               ram_we    = 1'b1;
               ram_waddr = {bank_ff, fs_idx_ff};
               ram_wdata = {level_ff, VALUE_UNSET, {1'b0, key_ff}};
               if (fs_del_ff && del_ff != '0) begin
                  del_in = del_ff - CW'(1);
               end
               live_in        = live_ff + CW'(1);
               rsp_valid_in   = 1'b1;
               rsp_created_in = 1'b1;
               state_in       = S_IDLE;
            end
         end

         S_GFILL: begin
            if (MW'(live_ff) >= MW'(fill_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               hash_start = 1'b1;
               mode_in    = M_INSERT;
               state_in   = S_HASH;
            end
         end

         S_POP_RD: begin
            ram_raddr = {bank_ff, sweep_ff[IW-1:0]};
            state_in  = S_POP_CHK;
         end

         S_POP_CHK: begin
            ram_waddr = {bank_ff, sweep_ff[IW-1:0]};
            if (rd_live && rd_lvl >= level_ff) begin
               ram_we     = 1'b1;
               ram_wdata  = {rd_lvl, rd_val, SLOT_DELETED};
               removed_in = removed_ff + CW'(1);
            end
            if (sweep_ff[IW-1:0] == LAST_IDX) begin
               state_in = S_POP_END;
            end else begin
               sweep_in = sweep_ff + AW'(1);
               state_in = S_POP_RD;
            end
         end

         S_POP_END: begin
            live_in  = pop_live;
            del_in   = pop_del;
            level_in = level_ff - LEVEL_BITS'(1);
            if (MW'(pop_del) >= MW'(clean_ff)) begin
               sweep_in  = '0;
               rh_get_in = 1'b0;
               state_in  = S_RH_CLR;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = rem32[10:0];
               state_in       = S_IDLE;
            end
         end

         S_RH_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = {!bank_ff, sweep_ff[IW-1:0]};
            ram_wdata = {{LEVEL_BITS{1'b0}}, 32'd0, SLOT_EMPTY};
            if (sweep_ff[IW-1:0] == LAST_IDX) begin
               sweep_in = '0;
               state_in = S_RH_RD;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end

         S_RH_RD: begin
            ram_raddr = {bank_ff, sweep_ff[IW-1:0]};
            state_in  = S_RH_CHK;
         end

         S_RH_CHK: begin
            if (rd_live) begin
               mv_in      = ram_rdata;
               hash_start = 1'b1;
               mix_key    = rd_key;
               mode_in    = M_MOVE;
               state_in   = S_HASH;
            end else begin
               state_in = S_RH_NEXT;
            end
         end

         S_RH_NEXT: begin
            if (sweep_ff[IW-1:0] == LAST_IDX) begin
               bank_in = !bank_ff;
               del_in  = '0;
               if (rh_get_ff) begin
                  state_in = S_GFILL;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_removed_in = rem32[10:0];
                  state_in       = S_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + AW'(1);
               state_in = S_RH_RD;
            end
         end

         default: state_in = S_IDLE;
      endcase

      rsp_level_in = lvl32[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rh_get_ff    <= 1'b0;
         mode_ff      <= M_LOOKUP;
         bank_ff      <= 1'b0;
         live_ff      <= '0;
         del_ff       <= '0;
         removed_ff   <= '0;
         level_ff     <= '0;
         fill_ff      <= CFG_W'(716);
         clean_ff     <= CFG_W'(204);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         rh_get_ff    <= rh_get_in;
         mode_ff      <= mode_in;
         bank_ff      <= bank_in;
         live_ff      <= live_in;
         del_ff       <= del_in;
         removed_ff   <= removed_in;
         level_ff     <= level_in;
         fill_ff      <= fill_in;
         clean_ff     <= clean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      nv_ff          <= nv_in;
      idx_ff         <= idx_in;
      n_ff           <= n_in;
      fs_idx_ff      <= fs_idx_in;
      fs_del_ff      <= fs_del_in;
      mv_ff          <= mv_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_created_ff <= rsp_created_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_level_ff   <= rsp_level_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_created       = rsp_created_ff;
   assign rsp_entry_value   = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_level_now     = rsp_level_ff;

   // a result only follows work that was in flight or just accepted
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result beat without a request");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither worked on nor answered");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (MW'(live_ff) + MW'(del_ff)) <= MW'(TABLE_SIZE))
      else $error("live plus deleted count exceeds table size");

   a_found_xor_created: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_created))
      else $error("result both found and created");

endmodule
